[rtl/core/sst_pkg.sv]
package sst_pkg;

    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int DUTY_W      = 8;
    localparam int TARGET_W    = 32;
    localparam int TOL_W       = 11;
    localparam int LEG_W       = 2;
    localparam int STEP_W      = 3;

    typedef enum logic [1:0] {
        MODE_HALT    = 2'd0,
        MODE_FORWARD = 2'd1,
        MODE_REVERSE = 2'd2,
        MODE_SEEK    = 2'd3
    } drive_mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DRIVE_MODE       = 2'd0,
        CFG_PWM_DUTY         = 2'd1,
        CFG_TARGET_POSITION  = 2'd2,
        CFG_TOLERANCE_COUNTS = 2'd3
    } cfg_index_t;

    typedef enum logic [LEG_W-1:0] {
        LEG_A = 2'd0,
        LEG_B = 2'd1,
        LEG_C = 2'd2
    } leg_t;

    localparam logic [DUTY_W-1:0] DUTY_RESET = 8'd128;
    localparam logic [TOL_W-1:0]  TOL_RESET  = 11'd22;
    localparam logic [STEP_W-1:0] STEP_LAST  = 3'd5;

    typedef struct packed {
        drive_mode_t                 drive_mode;
        logic [DUTY_W-1:0]           pwm_duty;
        logic signed [TARGET_W-1:0]  target_position;
        logic [TOL_W-1:0]            tolerance_counts;
    } cfg_t;

    function automatic leg_t leg_high(input logic [STEP_W-1:0] step);
        leg_t leg;
        unique case (step)
            3'd0, 3'd1: leg = LEG_A;
            3'd2, 3'd3: leg = LEG_B;
            3'd4, 3'd5: leg = LEG_C;
            default:    leg = LEG_A;
        endcase
        return leg;
    endfunction

    function automatic leg_t leg_low(input logic [STEP_W-1:0] step);
        leg_t leg;
        unique case (step)
            3'd0:       leg = LEG_B;
            3'd1, 3'd2: leg = LEG_C;
            3'd3, 3'd4: leg = LEG_A;
            3'd5:       leg = LEG_B;
            default:    leg = LEG_A;
        endcase
        return leg;
    endfunction

endpackage

[rtl/core/sst_if.sv]
interface sst_encoder_if #(
    parameter int ENCODER_BITS = 12
);
    logic                    valid;
    logic                    ready;
    logic [ENCODER_BITS-1:0] encoder_count;

    modport source (output valid, output encoder_count, input ready);
    modport sink   (input valid, input encoder_count, output ready);
endinterface

interface sst_command_if #(
    parameter int POSITION_BITS = 32
);
    logic                            valid;
    logic                            ready;
    logic                            drive_on;
    logic [sst_pkg::LEG_W-1:0]       high_leg;
    logic [sst_pkg::LEG_W-1:0]       low_leg;
    logic [sst_pkg::DUTY_W-1:0]      high_level;
    logic [sst_pkg::STEP_W-1:0]      applied_step;
    logic signed [POSITION_BITS-1:0] position;
    logic                            within_band;

    modport source (
        output valid, output drive_on, output high_leg, output low_leg,
        output high_level, output applied_step, output position,
        output within_band, input ready
    );
    modport sink (
        input valid, input drive_on, input high_leg, input low_leg,
        input high_level, input applied_step, input position,
        input within_band, output ready
    );
endinterface

[rtl/core/six_step_commutation_position_stepper_top.sv]
// Six-step commutation stepper with encoder unwrap.
// The encoder channel carries one absolute encoder reading per control tick; each
// accepted transaction yields exactly one transaction on the command channel with
// the driven leg pair, the PWM level, the applied step, the unwrapped position and
// the in-band flag. Configuration is written through cfg_we, cfg_index and cfg_data
// while no transaction is in flight.
// A reading passes an input register, the unwrap stage (position register) and the
// drive stage (result register), in that order. One transaction is taken every
// cycle while the receiver keeps ready high; the step and position feedback each
// close within a single stage.
// Reset clears the pipeline, the position, the step and the primed flag, and loads
// the register defaults: stop mode, duty 128, target 0, tolerance 22. The first
// reading after reset only primes the unwrap.
// When the receiver holds ready low, the result register holds its transaction and
// the stages behind it fill; ready on the encoder channel falls once all three
// registers are occupied, and nothing is lost or repeated.
module six_step_commutation_position_stepper_top #(
    parameter int ENCODER_BITS  = 12,
    parameter int POSITION_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [sst_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sst_pkg::CFG_DATA_W-1:0]  cfg_data,
    sst_encoder_if.sink                     encoder,
    sst_command_if.source                   command
);

    sst_pkg::cfg_t                   cfg;
    logic                            pos_valid;
    logic                            pos_ready;
    logic signed [POSITION_BITS-1:0] position;

    sst_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sst_unwrap #(
        .ENCODER_BITS  (ENCODER_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_unwrap (
        .clk       (clk),
        .rst_n     (rst_n),
        .encoder   (encoder),
        .pos_valid (pos_valid),
        .pos_ready (pos_ready),
        .position  (position)
    );

    sst_drive #(
        .POSITION_BITS (POSITION_BITS)
    ) u_drive (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pos_valid (pos_valid),
        .pos_ready (pos_ready),
        .position  (position),
        .command   (command)
    );

endmodule

[rtl/core/sst_cfg_regs.sv]
module sst_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [sst_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [sst_pkg::CFG_DATA_W-1:0]    cfg_data,
    output sst_pkg::cfg_t                     cfg
);

    sst_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.drive_mode       <= sst_pkg::MODE_HALT;
            cfg_reg.pwm_duty         <= sst_pkg::DUTY_RESET;
            cfg_reg.target_position  <= '0;
            cfg_reg.tolerance_counts <= sst_pkg::TOL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (sst_pkg::cfg_index_t'(cfg_index))
                sst_pkg::CFG_DRIVE_MODE:
                    cfg_reg.drive_mode <= sst_pkg::drive_mode_t'(cfg_data[1:0]);
                sst_pkg::CFG_PWM_DUTY:
                    cfg_reg.pwm_duty <= cfg_data[sst_pkg::DUTY_W-1:0];
                sst_pkg::CFG_TARGET_POSITION:
                    cfg_reg.target_position <= signed'(cfg_data[sst_pkg::TARGET_W-1:0]);
                sst_pkg::CFG_TOLERANCE_COUNTS:
                    cfg_reg.tolerance_counts <= cfg_data[sst_pkg::TOL_W-1:0];
                default:
                    cfg_reg.drive_mode <= cfg_reg.drive_mode;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/core/sst_unwrap.sv]
module sst_unwrap #(
    parameter int ENCODER_BITS  = 12,
    parameter int POSITION_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    sst_encoder_if.sink                     encoder,
    output logic                            pos_valid,
    input  logic                            pos_ready,
    output logic signed [POSITION_BITS-1:0] position
);

    localparam int D_W   = ENCODER_BITS + 2;
    localparam int SUM_W = ((POSITION_BITS > D_W) ? POSITION_BITS : D_W) + 1;
    localparam logic signed [D_W-1:0] TURN = D_W'(64'sd1 <<< ENCODER_BITS);
    localparam logic signed [D_W-1:0] HALF = D_W'(64'sd1 <<< (ENCODER_BITS - 1));
    localparam logic signed [SUM_W-1:0] PMAX =
        SUM_W'((64'sd1 <<< (POSITION_BITS - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] PMIN = -PMAX - SUM_W'(1);

    logic                            in_valid_reg;
    logic [ENCODER_BITS-1:0]         raw_reg;
    logic [ENCODER_BITS-1:0]         prev_reg;
    logic                            primed_reg;
    logic signed [POSITION_BITS-1:0] pos_reg;
    logic                            pos_valid_reg;

    logic                            out_free;
    logic                            advance;
    logic                            in_free;
    logic signed [D_W-1:0]           delta_raw;
    logic signed [D_W-1:0]           delta;
    logic signed [SUM_W-1:0]         sum;
    logic signed [POSITION_BITS-1:0] pos_next;

    assign out_free      = !pos_valid_reg || pos_ready;
    assign advance       = in_valid_reg && out_free;
    assign in_free       = !in_valid_reg || out_free;
    assign encoder.ready = in_free;

    always_comb
    begin
        delta_raw = signed'({2'b00, raw_reg}) - signed'({2'b00, prev_reg});
        delta     = delta_raw;
        if (delta_raw > HALF)
        begin
            delta = delta_raw - TURN;
        end
        else if (delta_raw < -HALF)
        begin
            delta = delta_raw + TURN;
        end
        sum = SUM_W'(pos_reg) + SUM_W'(delta);
        priority if (!primed_reg)
        begin
            pos_next = pos_reg;
        end
        else if (sum > PMAX)
        begin
            pos_next = PMAX[POSITION_BITS-1:0];
        end
        else if (sum < PMIN)
        begin
            pos_next = PMIN[POSITION_BITS-1:0];
        end
        else
        begin
            pos_next = sum[POSITION_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            pos_valid_reg <= 1'b0;
            primed_reg    <= 1'b0;
            prev_reg      <= '0;
            pos_reg       <= '0;
        end
        else
        begin
            if (in_free)
            begin
                in_valid_reg <= encoder.valid;
            end
            if (out_free)
            begin
                pos_valid_reg <= advance;
            end
            if (advance)
            begin
                primed_reg <= 1'b1;
                prev_reg   <= raw_reg;
                pos_reg    <= pos_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_free && encoder.valid)
        begin
            raw_reg <= encoder.encoder_count;
        end
    end

    assign pos_valid = pos_valid_reg;
    assign position  = pos_reg;

endmodule

[rtl/core/sst_drive.sv]
module sst_drive #(
    parameter int POSITION_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sst_pkg::cfg_t                   cfg,
    input  logic                            pos_valid,
    output logic                            pos_ready,
    input  logic signed [POSITION_BITS-1:0] position,
    sst_command_if.source                   command
);

    localparam int ERR_W =
        ((POSITION_BITS > sst_pkg::TARGET_W) ? POSITION_BITS : sst_pkg::TARGET_W) + 1;

    logic [sst_pkg::STEP_W-1:0]      step_reg;
    logic                            res_valid_reg;
    logic                            drive_on_reg;
    logic [sst_pkg::LEG_W-1:0]       high_leg_reg;
    logic [sst_pkg::LEG_W-1:0]       low_leg_reg;
    logic [sst_pkg::DUTY_W-1:0]      high_level_reg;
    logic [sst_pkg::STEP_W-1:0]      applied_step_reg;
    logic signed [POSITION_BITS-1:0] position_reg;
    logic                            within_band_reg;

    logic                            out_free;
    logic                            advance;
    logic signed [ERR_W-1:0]         err;
    logic [ERR_W-1:0]                mag;
    logic                            band;
    logic                            drive;
    logic                            fwd;
    logic [sst_pkg::STEP_W-1:0]      step_next;

    assign out_free  = !res_valid_reg || command.ready;
    assign advance   = pos_valid && out_free;
    assign pos_ready = out_free;

    always_comb
    begin
        err  = ERR_W'(cfg.target_position) - ERR_W'(position);
        mag  = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
        band = mag <= ERR_W'(cfg.tolerance_counts);
        drive = 1'b0;
        fwd   = 1'b1;
        unique case (cfg.drive_mode)
            sst_pkg::MODE_HALT:
            begin
                drive = 1'b0;
            end
            sst_pkg::MODE_FORWARD:
            begin
                drive = 1'b1;
            end
            sst_pkg::MODE_REVERSE:
            begin
                drive = 1'b1;
                fwd   = 1'b0;
            end
            sst_pkg::MODE_SEEK:
            begin
                drive = !band;
                fwd   = !err[ERR_W-1] && (err != '0);
            end
            default:
            begin
                drive = 1'b0;
            end
        endcase
        if (fwd)
        begin
            step_next = (step_reg == sst_pkg::STEP_LAST) ? '0 : step_reg + 3'd1;
        end
        else
        begin
            step_next = (step_reg == '0) ? sst_pkg::STEP_LAST : step_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            if (out_free)
            begin
                res_valid_reg <= pos_valid;
            end
            if (advance && drive)
            begin
                step_reg <= step_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            drive_on_reg     <= drive;
            high_leg_reg     <= drive ? sst_pkg::leg_high(step_reg) : sst_pkg::LEG_A;
            low_leg_reg      <= drive ? sst_pkg::leg_low(step_reg) : sst_pkg::LEG_A;
            high_level_reg   <= drive ? cfg.pwm_duty : '0;
            applied_step_reg <= drive ? step_reg : '0;
            position_reg     <= position;
            within_band_reg  <= band;
        end
    end

    assign command.valid        = res_valid_reg;
    assign command.drive_on     = drive_on_reg;
    assign command.high_leg     = high_leg_reg;
    assign command.low_leg      = low_leg_reg;
    assign command.high_level   = high_level_reg;
    assign command.applied_step = applied_step_reg;
    assign command.position     = position_reg;
    assign command.within_band  = within_band_reg;

endmodule

[test/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic                        drive_on;
        sst_pkg::leg_t               high_leg;
        sst_pkg::leg_t               low_leg;
        logic [sst_pkg::DUTY_W-1:0]  high_level;
        logic [sst_pkg::STEP_W-1:0]  applied_step;
        logic signed [31:0]          position;
        logic                        within_band;
    } command_t;

    typedef struct packed {
        logic                                setup;
        logic                                typed;
        sst_pkg::drive_mode_t                mode;
        logic [sst_pkg::DUTY_W-1:0]          duty;
        logic signed [sst_pkg::TARGET_W-1:0] target;
        logic [sst_pkg::TOL_W-1:0]           tol;
        logic [11:0]                         count;
        command_t                            result;
    } probe_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [sst_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [sst_pkg::CFG_DATA_W-1:0] cfg_data;

    sst_encoder_if #(.ENCODER_BITS(12)) enc_if ();
    sst_command_if #(.POSITION_BITS(32)) cmd_if ();

    six_step_commutation_position_stepper_top #(
        .ENCODER_BITS  (12),
        .POSITION_BITS (32)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .encoder   (enc_if),
        .command   (cmd_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sst_pkg::drive_mode_t cfg_mode;
    logic [sst_pkg::DUTY_W-1:0] cfg_duty;
    logic signed [sst_pkg::TARGET_W-1:0] cfg_target;
    logic [sst_pkg::TOL_W-1:0] cfg_tol;

    logic signed [31:0] meas_position;
    logic [11:0] last_count;
    logic unwrap_primed;
    logic [sst_pkg::STEP_W-1:0] commut_step;

    sst_pkg::leg_t high_of [0:5] = '{sst_pkg::LEG_A, sst_pkg::LEG_A, sst_pkg::LEG_B,
                                     sst_pkg::LEG_B, sst_pkg::LEG_C, sst_pkg::LEG_C};
    sst_pkg::leg_t low_of [0:5] = '{sst_pkg::LEG_B, sst_pkg::LEG_C, sst_pkg::LEG_C,
                                    sst_pkg::LEG_A, sst_pkg::LEG_A, sst_pkg::LEG_B};

    command_t commands_due [$];
    probe_t script [$];
    int mismatch_count = 0;
    int src_gap_pct = 0;
    int sink_stall_pct = 0;

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
        begin
            note_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
        end
    endtask

    function automatic command_t next_command(input logic [11:0] count);
        int cur;
        int prev;
        int delta;
        longint sum;
        longint err;
        longint mag;
        logic band;
        logic drive;
        logic ahead;
        logic [sst_pkg::STEP_W-1:0] s;
        command_t c;
        cur = count;
        prev = last_count;
        if (!unwrap_primed)
        begin
            unwrap_primed = 1'b1;
        end
        else
        begin
            delta = cur - prev;
            if (delta > 2048)
                delta -= 4096;
            if (delta < -2048)
                delta += 4096;
            sum = longint'(meas_position) + delta;
            if (sum > POS_MAX)
                sum = POS_MAX;
            if (sum < POS_MIN)
                sum = POS_MIN;
            meas_position = sum[31:0];
        end
        last_count = count;

        err = longint'(cfg_target) - longint'(meas_position);
        mag = (err < 0) ? -err : err;
        band = (mag <= cfg_tol);

        drive = 1'b0;
        ahead = 1'b1;
        case (cfg_mode)
            sst_pkg::MODE_FORWARD:
            begin
                drive = 1'b1;
            end
            sst_pkg::MODE_REVERSE:
            begin
                drive = 1'b1;
                ahead = 1'b0;
            end
            sst_pkg::MODE_SEEK:
            begin
                if (!band)
                begin
                    drive = 1'b1;
                    ahead = (err > 0);
                end
            end
            default:
            begin
            end
        endcase

        s = commut_step;
        c = '0;
        c.position = meas_position;
        c.within_band = band;
        if (drive)
        begin
            c.drive_on = 1'b1;
            c.high_leg = high_of[s];
            c.low_leg = low_of[s];
            c.high_level = cfg_duty;
            c.applied_step = s;
            if (ahead)
                commut_step = (s == sst_pkg::STEP_LAST) ? '0 : s + 1'b1;
            else
                commut_step = (s == '0) ? sst_pkg::STEP_LAST : s - 1'b1;
        end
        return c;
    endfunction

    function automatic logic [11:0] next_count(input logic [11:0] from);
        int pick;
        int delta;
        pick = $urandom_range(99);
        if (pick < 70)
            delta = int'($urandom_range(128)) - 64;
        else if (pick < 85)
            delta = int'($urandom_range(4094)) - 2047;
        else if (pick < 90)
            delta = 2048;
        else if (pick < 95)
            delta = ($urandom_range(1) != 0) ? 2049 : -2049;
        else
            return 12'($urandom_range(4095));
        return from + delta[11:0];
    endfunction

    function automatic probe_t tick_row(input logic [11:0] count, input logic on,
                                        input sst_pkg::leg_t hi, input sst_pkg::leg_t lo,
                                        input logic [sst_pkg::DUTY_W-1:0] level,
                                        input logic [sst_pkg::STEP_W-1:0] step,
                                        input int pos, input logic band);
        probe_t row;
        row = '0;
        row.typed = 1'b1;
        row.count = count;
        row.result.drive_on = on;
        row.result.high_leg = hi;
        row.result.low_leg = lo;
        row.result.high_level = level;
        row.result.applied_step = step;
        row.result.position = pos;
        row.result.within_band = band;
        return row;
    endfunction

    function automatic probe_t free_row(input logic [11:0] count);
        probe_t row;
        row = '0;
        row.count = count;
        return row;
    endfunction

    function automatic probe_t setup_row(input sst_pkg::drive_mode_t m,
                                         input logic [sst_pkg::DUTY_W-1:0] duty,
                                         input logic signed [31:0] target,
                                         input logic [sst_pkg::TOL_W-1:0] tol);
        probe_t row;
        row = '0;
        row.setup = 1'b1;
        row.mode = m;
        row.duty = duty;
        row.target = target;
        row.tol = tol;
        return row;
    endfunction

    task automatic send_count(input logic [11:0] count, input logic fixed,
                              input command_t fixed_result);
        command_t want;
        while ($urandom_range(99) < src_gap_pct)
        begin
            enc_if.valid <= 1'b0;
            @(posedge clk);
        end
        enc_if.valid <= 1'b1;
        enc_if.encoder_count <= count;
        do
            @(posedge clk);
        while (!enc_if.ready);
        want = next_command(count);
        if (fixed)
            want = fixed_result;
        commands_due.push_back(want);
    endtask

    task automatic settle();
        enc_if.valid <= 1'b0;
        while (commands_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input sst_pkg::cfg_index_t idx,
                             input logic [sst_pkg::CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            sst_pkg::CFG_DRIVE_MODE:
                cfg_mode = sst_pkg::drive_mode_t'(data[1:0]);
            sst_pkg::CFG_PWM_DUTY:
                cfg_duty = data[sst_pkg::DUTY_W-1:0];
            sst_pkg::CFG_TARGET_POSITION:
                cfg_target = data[sst_pkg::TARGET_W-1:0];
            sst_pkg::CFG_TOLERANCE_COUNTS:
                cfg_tol = data[sst_pkg::TOL_W-1:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic configure(input sst_pkg::drive_mode_t m,
                             input logic [sst_pkg::DUTY_W-1:0] duty,
                             input logic signed [31:0] target,
                             input logic [sst_pkg::TOL_W-1:0] tol);
        settle();
        write_reg(sst_pkg::CFG_DRIVE_MODE, {30'd0, m});
        write_reg(sst_pkg::CFG_PWM_DUTY, {24'd0, duty});
        write_reg(sst_pkg::CFG_TARGET_POSITION, target);
        write_reg(sst_pkg::CFG_TOLERANCE_COUNTS, {21'd0, tol});
        cfg_we <= 1'b0;
    endtask

    task automatic random_setup();
        int pick;
        sst_pkg::drive_mode_t m;
        logic [sst_pkg::DUTY_W-1:0] duty;
        logic [sst_pkg::TOL_W-1:0] tol;
        logic signed [31:0] target;
        pick = $urandom_range(9);
        if (pick < 2)
            m = sst_pkg::MODE_HALT;
        else if (pick < 4)
            m = sst_pkg::MODE_FORWARD;
        else if (pick < 6)
            m = sst_pkg::MODE_REVERSE;
        else
            m = sst_pkg::MODE_SEEK;
        case ($urandom_range(3))
            0: duty = '0;
            1: duty = '1;
            default: duty = sst_pkg::DUTY_W'($urandom_range(255));
        endcase
        case ($urandom_range(3))
            0: tol = '0;
            1: tol = '1;
            default: tol = sst_pkg::TOL_W'($urandom_range(300));
        endcase
        pick = $urandom_range(9);
        if (pick < 5)
            target = meas_position + (int'($urandom_range(6000)) - 3000);
        else if (pick == 5)
            target = POS_MAX;
        else if (pick == 6)
            target = POS_MIN;
        else
            target = $urandom;
        configure(m, duty, target, tol);
    endtask

    task automatic random_segments(input int segments);
        repeat (segments)
        begin
            random_setup();
            repeat (95)
                send_count(next_count(last_count), 1'b0, '0);
        end
    endtask

    initial
    begin
        #100_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        cmd_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (cmd_if.valid && cmd_if.ready)
            begin
                if (commands_due.size() == 0)
                begin
                    note_mismatch("command transaction with no reading outstanding");
                end
                else
                begin
                    command_t want;
                    want = commands_due.pop_front();
                    compare_field("drive_on", cmd_if.drive_on, want.drive_on);
                    compare_field("high_leg", cmd_if.high_leg, want.high_leg);
                    compare_field("low_leg", cmd_if.low_leg, want.low_leg);
                    compare_field("high_level", cmd_if.high_level, want.high_level);
                    compare_field("applied_step", cmd_if.applied_step, want.applied_step);
                    compare_field("position", cmd_if.position, want.position);
                    compare_field("within_band", cmd_if.within_band, want.within_band);
                end
            end
            cmd_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = sst_pkg::CFG_DRIVE_MODE;
        cfg_data = '0;
        enc_if.valid = 1'b0;
        enc_if.encoder_count = '0;

        cfg_mode = sst_pkg::MODE_HALT;
        cfg_duty = sst_pkg::DUTY_RESET;
        cfg_target = '0;
        cfg_tol = sst_pkg::TOL_RESET;
        meas_position = '0;
        last_count = '0;
        unwrap_primed = 1'b0;
        commut_step = '0;

        script = {
            tick_row(12'hABC, 1'b0, sst_pkg::LEG_A, sst_pkg::LEG_A, 8'd0, 3'd0, 0, 1'b1),
            free_row(12'hFFF),
            free_row(12'h000),
            free_row(12'hFFF),
            tick_row(12'h7FF, 1'b0, sst_pkg::LEG_A, sst_pkg::LEG_A, 8'd0, 3'd0, -701, 1'b0),
            tick_row(12'hFFF, 1'b0, sst_pkg::LEG_A, sst_pkg::LEG_A, 8'd0, 3'd0, 1347, 1'b0),
            tick_row(12'h7FE, 1'b0, sst_pkg::LEG_A, sst_pkg::LEG_A, 8'd0, 3'd0, 3394, 1'b0),
            setup_row(sst_pkg::MODE_SEEK, 8'd200, 32'sd3394, 11'd0),
            free_row(12'h7FE),
            free_row(12'h7FF),
            free_row(12'h7FF),
            free_row(12'h7FD),
            setup_row(sst_pkg::MODE_FORWARD, 8'd0, POS_MIN, 11'd2047),
            free_row(12'h000),
            free_row(12'hFFF),
            setup_row(sst_pkg::MODE_REVERSE, 8'd255, POS_MAX, 11'd2047),
            free_row(12'hFFF),
            free_row(12'h800),
            free_row(12'h800),
            setup_row(sst_pkg::MODE_HALT, 8'd1, 32'sd1347, 11'd2047),
            tick_row(12'h800, 1'b0, sst_pkg::LEG_A, sst_pkg::LEG_A, 8'd0, 3'd0, -700, 1'b1),
            tick_row(12'h7FF, 1'b0, sst_pkg::LEG_A, sst_pkg::LEG_A, 8'd0, 3'd0, -701, 1'b0)
        };

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;

        src_gap_pct = 13;
        sink_stall_pct = 59;
        foreach (script[i])
        begin
            if (script[i].setup)
                configure(script[i].mode, script[i].duty, script[i].target, script[i].tol);
            else
                send_count(script[i].count, script[i].typed, script[i].result);
        end
        random_segments(6);

        src_gap_pct = 59;
        sink_stall_pct = 13;
        random_segments(6);

        src_gap_pct = 0;
        sink_stall_pct = 0;
        random_segments(6);

        configure(sst_pkg::MODE_FORWARD, sst_pkg::DUTY_W'($urandom_range(255)), POS_MAX,
                  11'd2047);
        repeat (30)
            send_count(next_count(last_count), 1'b0, '0);
        configure(sst_pkg::MODE_SEEK, sst_pkg::DUTY_W'($urandom_range(255)), POS_MIN, 11'd0);
        repeat (30)
            send_count(next_count(last_count), 1'b0, '0);

        settle();
        repeat (8)
            @(posedge clk);
        if (mismatch_count == 0 && commands_due.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[six_step_commutation_position_stepper_top.f]
rtl/core/sst_pkg.sv
rtl/core/sst_if.sv
rtl/core/sst_cfg_regs.sv
rtl/core/sst_unwrap.sv
rtl/core/sst_drive.sv
rtl/core/six_step_commutation_position_stepper_top.sv
test/tb_top.sv
